// ===== src/jse_pkg.sv =====
// Shared types, character codes and helper functions for the JSON string escaper.
// Used by the front, queue, back and top-level modules; depends on nothing.
package jse_pkg;

    // Default depth of the command queue between front and back.
    localparam int JSE_QUEUE_DEPTH = 4;

    // Command kinds passed from the front to the back.
    localparam logic [1:0] KIND_PLAIN = 2'd0;
    localparam logic [1:0] KIND_ESC   = 2'd1;
    localparam logic [1:0] KIND_UNI   = 2'd2;

    // Character codes.
    localparam logic [7:0] CHR_QUOTE  = 8'h22;
    localparam logic [7:0] CHR_BSLASH = 8'h5C;
    localparam logic [7:0] CHR_BS     = 8'h08;
    localparam logic [7:0] CHR_FF     = 8'h0C;
    localparam logic [7:0] CHR_LF     = 8'h0A;
    localparam logic [7:0] CHR_CR     = 8'h0D;
    localparam logic [7:0] CHR_TAB    = 8'h09;
    localparam logic [7:0] CHR_LO_B   = 8'h62;
    localparam logic [7:0] CHR_LO_F   = 8'h66;
    localparam logic [7:0] CHR_LO_N   = 8'h6E;
    localparam logic [7:0] CHR_LO_R   = 8'h72;
    localparam logic [7:0] CHR_LO_T   = 8'h74;
    localparam logic [7:0] CHR_LO_U   = 8'h75;
    localparam logic [7:0] CHR_ZERO   = 8'h30;
    localparam logic [7:0] CHR_ALPHA  = 8'h37;

    // UTF-8 lead boundary: lead bytes from this value up open three-byte sequences.
    localparam logic [7:0] LEAD_THREE = 8'hE0;

    // One command: what kind of run to emit and its payload.
    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] data;
    } t_cmd;

    // Uppercase hex digit of a nibble.
    function automatic logic [7:0] jse_hex(input logic [3:0] nib);
        logic [7:0] wide;
        wide = {4'd0, nib};
        return (nib < 4'd10) ? (CHR_ZERO + wide) : (CHR_ALPHA + wide);
    endfunction

    // Index of the final byte in the run for a command kind.
    function automatic logic [2:0] jse_last_idx(input logic [1:0] kind);
        logic [2:0] res;
        unique case (kind)
            KIND_PLAIN: res = 3'd0;
            KIND_ESC:   res = 3'd1;
            KIND_UNI:   res = 3'd5;
            default:    res = 3'd0;
        endcase
        return res;
    endfunction

    // Byte number idx of the run that a command produces.
    function automatic logic [7:0] jse_char_at(input t_cmd cmd, input logic [2:0] idx);
        logic [7:0] res;
        res = cmd.data[7:0];
        unique case (cmd.kind)
            KIND_PLAIN: res = cmd.data[7:0];
            KIND_ESC:   res = (idx == 3'd0) ? CHR_BSLASH : cmd.data[7:0];
            KIND_UNI: begin
                unique case (idx)
                    3'd0:    res = CHR_BSLASH;
                    3'd1:    res = CHR_LO_U;
                    3'd2:    res = jse_hex(cmd.data[15:12]);
                    3'd3:    res = jse_hex(cmd.data[11:8]);
                    3'd4:    res = jse_hex(cmd.data[7:4]);
                    default: res = jse_hex(cmd.data[3:0]);
                endcase
            end
            default:    res = cmd.data[7:0];
        endcase
        return res;
    endfunction

endpackage

// ===== src/json_string_escaper_top.sv =====
// A command is registered in the command queue, then its bytes in the output register.
// The output sequencer emits one output byte per cycle unless stalled: a plain byte
// yields one byte, a two-character escape two, a finished UTF-8 sequence six, a lead none.
// The front accepts while the command queue has room, one word per cycle.
// Reset is synchronous and active low; it clears sequence state, queue and output.
module json_string_escaper_top #(
    parameter int QUEUE_DEPTH = jse_pkg::JSE_QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_byte_in,
    input  logic       i_start_of_string,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_char_out,
    output logic       o_last_of_run
);

    logic          s_accept;
    logic          s_push;
    logic          s_pop;
    logic          s_full;
    logic          s_empty;
    jse_pkg::t_cmd s_cmd;
    jse_pkg::t_cmd s_head;

    assign o_in_ready = !s_full;
    assign s_accept   = i_in_valid && o_in_ready;

    // Front end: sequence tracking and classification.
    jse_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_accept          (s_accept),
        .i_byte_in         (i_byte_in),
        .i_start_of_string (i_start_of_string),
        .o_push            (s_push),
        .o_cmd             (s_cmd)
    );

    // Command queue.
    jse_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_push),
        .i_cmd   (s_cmd),
        .i_pop   (s_pop),
        .o_head  (s_head),
        .o_full  (s_full),
        .o_empty (s_empty)
    );

    // Output sequencer.
    jse_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (s_head),
        .i_empty       (s_empty),
        .o_pop         (s_pop),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_char_out    (o_char_out),
        .o_last_of_run (o_last_of_run)
    );

    // A command is never pushed into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_push |-> !s_full)
        else $error("command pushed into full queue");

    // A command is never popped from an empty queue.
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_pop |-> !s_empty)
        else $error("command popped from empty queue");

    // Retiring a command leaves the final byte of its run in the output register.
    a_pop_marks_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_pop |=> (o_out_valid && o_last_of_run))
        else $error("retired command without a final byte");

    // A backslash that opens a run is never the final byte of that run.
    a_escape_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_pop && (s_head.kind != jse_pkg::KIND_PLAIN)
            && (s_head.data[7:0] != jse_pkg::CHR_BSLASH))
        |=> (o_char_out != jse_pkg::CHR_BSLASH))
        else $error("escape run ended on its leading backslash");

endmodule

// ===== src/jse_front.sv =====
// Front end of the JSON string escaper: tracks UTF-8 sequence state and
// turns each accepted word into at most one command. Depends on jse_pkg.
module jse_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic [7:0]     i_byte_in,
    input  logic           i_start_of_string,
    output logic           o_push,
    output jse_pkg::t_cmd  o_cmd
);

    logic [1:0]  r_pend;
    logic [15:0] r_acc;
    logic [1:0]  n_pend;
    logic [15:0] n_acc;
    logic [1:0]  s_pend;
    logic [15:0] s_acc;
    logic [7:0]  s_esc;
    logic        s_has_out;

    // Start of string drops a partial sequence before the byte is examined.
    assign s_pend = i_start_of_string ? 2'd0 : r_pend;
    assign s_acc  = i_start_of_string ? 16'd0 : r_acc;

    // Two-character escape lookup; zero means none.
    always_comb begin
        unique case (i_byte_in)
            jse_pkg::CHR_QUOTE:  s_esc = jse_pkg::CHR_QUOTE;
            jse_pkg::CHR_BSLASH: s_esc = jse_pkg::CHR_BSLASH;
            jse_pkg::CHR_BS:     s_esc = jse_pkg::CHR_LO_B;
            jse_pkg::CHR_FF:     s_esc = jse_pkg::CHR_LO_F;
            jse_pkg::CHR_LF:     s_esc = jse_pkg::CHR_LO_N;
            jse_pkg::CHR_CR:     s_esc = jse_pkg::CHR_LO_R;
            jse_pkg::CHR_TAB:    s_esc = jse_pkg::CHR_LO_T;
            default:             s_esc = 8'd0;
        endcase
    end

    // Classify the byte and compute the next sequence state.
    always_comb begin
        n_pend    = s_pend;
        n_acc     = s_acc;
        s_has_out = 1'b0;
        o_cmd     = '{kind: jse_pkg::KIND_PLAIN, data: {8'd0, i_byte_in}};
        priority if (s_pend != 2'd0) begin
            n_acc  = {s_acc[9:0], i_byte_in[5:0]};
            n_pend = s_pend - 2'd1;
            if (n_pend == 2'd0) begin
                s_has_out = 1'b1;
                o_cmd     = '{kind: jse_pkg::KIND_UNI, data: n_acc};
            end
        end else if (i_byte_in[7]) begin
            if (i_byte_in < jse_pkg::LEAD_THREE) begin
                n_acc  = {11'd0, i_byte_in[4:0]};
                n_pend = 2'd1;
            end else begin
                n_acc  = {12'd0, i_byte_in[3:0]};
                n_pend = 2'd2;
            end
        end else if (s_esc != 8'd0) begin
            s_has_out = 1'b1;
            o_cmd     = '{kind: jse_pkg::KIND_ESC, data: {8'd0, s_esc}};
        end else begin
            s_has_out = 1'b1;
        end
    end

    assign o_push = i_accept && s_has_out;

    // Sequence state advances only on an accepted word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 2'd0;
            r_acc  <= 16'd0;
        end else if (i_accept) begin
            r_pend <= n_pend;
            r_acc  <= n_acc;
        end
    end

endmodule

// ===== src/jse_queue.sv =====
// Short command queue that decouples the front end from the output sequencer.
// Depends on jse_pkg for the command type.
module jse_queue #(
    parameter int DEPTH = jse_pkg::JSE_QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  jse_pkg::t_cmd  i_cmd,
    input  logic           i_pop,
    output jse_pkg::t_cmd  o_head,
    output logic           o_full,
    output logic           o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    jse_pkg::t_cmd r_mem [DEPTH];
    logic [PW-1:0] r_wptr;
    logic [PW-1:0] r_rptr;
    logic [CW-1:0] r_count;

    assign o_head  = r_mem[r_rptr];
    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);

    // Storage write.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == LAST_PTR) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == LAST_PTR) ? '0 : r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== src/jse_back.sv =====
// Output sequencer: expands the queue head command into escaped bytes in an
// output register, one per cycle unless stalled. Depends on jse_pkg.
module jse_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  jse_pkg::t_cmd  i_head,
    input  logic           i_empty,
    output logic           o_pop,
    input  logic           i_out_ready,
    output logic           o_out_valid,
    output logic [7:0]     o_char_out,
    output logic           o_last_of_run
);

    logic [2:0] r_idx;
    logic       r_out_valid;
    logic [7:0] r_out_char;
    logic       r_out_last;
    logic       s_slot_free;
    logic       s_emit;
    logic       s_last;

    assign s_slot_free = !r_out_valid || i_out_ready;
    assign s_emit      = s_slot_free && !i_empty;
    assign s_last      = (r_idx == jse_pkg::jse_last_idx(i_head.kind));
    assign o_pop       = s_emit && s_last;

    // Byte position within the current run.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 3'd0;
        end else if (s_emit) begin
            r_idx <= s_last ? 3'd0 : r_idx + 3'd1;
        end
    end

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_slot_free) begin
            r_out_valid <= !i_empty;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (s_emit) begin
            r_out_char <= jse_pkg::jse_char_at(i_head, r_idx);
            r_out_last <= s_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_char_out    = r_out_char;
    assign o_last_of_run = r_out_last;

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for json_string_escaper_top: a directed table, then random words.
// Depends on jse_pkg for character codes and on the top module's port list.
module testbench;

    localparam int RANDOM_WORDS = 295;
    localparam int STALL_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 20;

    // One byte of escaped text as it should leave the block.
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_out_char;

    // One row of the directed table; expect_len < 0 means the predictor decides.
    typedef struct {
        logic [7:0]  octet;
        logic        sos;
        int          expect_len;
        logic [47:0] expect_text;
    } t_dir_row;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    logic [7:0] i_byte_in;
    logic       i_start_of_string;
    logic       o_out_valid;
    logic       i_out_ready;
    logic [7:0] o_char_out;
    logic       o_last_of_run;

    t_out_char   expected_chars[$];
    t_dir_row    dir_rows[$];
    int          err_count;
    int          words_sent;
    logic [1:0]  seq_left;
    logic [15:0] seq_code;
    int          stretch_left[2];
    bit          calm[2];
    logic [7:0]  esc_set[7];

    json_string_escaper_top dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_byte_in         (i_byte_in),
        .i_start_of_string (i_start_of_string),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_char_out        (o_char_out),
        .o_last_of_run     (o_last_of_run)
    );

    // Free-running clock, period 10.
    initial begin
        i_clk = 1'b0;
    end
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH at %0t: %s got %02h want %02h", $time, what, got, want);
        err_count++;
    endtask

    // Appends one expected output byte at the tail of the queue.
    function automatic void add_expected(input t_out_char oc);
        expected_chars.insert(expected_chars.size(), oc);
    endfunction

    // Pause length for one side: mostly none or short, a few long, with calm stretches.
    function automatic int pick_pause(input int side);
        int roll;
        if (stretch_left[side] == 0) begin
            stretch_left[side] = $urandom_range(8, 40);
            calm[side] = ($urandom_range(0, 3) == 0);
        end
        stretch_left[side]--;
        roll = $urandom_range(0, 99);
        if (calm[side] || roll < 60) return 0;
        if (roll < 94) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Advances the escaper state by one word and, if asked, queues the text it produces.
    function automatic void predict_escape(input logic [7:0] b, input logic sos, input bit keep);
        logic [7:0] run [6];
        logic [7:0] esc;
        logic [3:0] nib;
        t_out_char  oc;
        int         n;
        n = 0;
        esc = 8'h00;
        if (sos) begin
            seq_left = 2'd0;
            seq_code = 16'd0;
        end
        if (seq_left != 2'd0) begin
            // Any byte counts as a continuation while a sequence is open.
            seq_code = {seq_code[9:0], b[5:0]};
            seq_left = seq_left - 2'd1;
            if (seq_left == 2'd0) begin
                run[0] = jse_pkg::CHR_BSLASH;
                run[1] = jse_pkg::CHR_LO_U;
                for (int i = 0; i < 4; i++) begin
                    nib = 4'(seq_code >> (12 - 4 * i));
                    run[2 + i] = (nib < 4'd10) ? jse_pkg::CHR_ZERO + 8'(nib)
                                               : jse_pkg::CHR_ALPHA + 8'(nib);
                end
                n = 6;
            end
        end else if (b >= 8'h80) begin
            if (b < jse_pkg::LEAD_THREE) begin
                seq_code = {11'd0, b[4:0]};
                seq_left = 2'd1;
            end else begin
                seq_code = {12'd0, b[3:0]};
                seq_left = 2'd2;
            end
        end else begin
            case (b)
                jse_pkg::CHR_QUOTE:  esc = jse_pkg::CHR_QUOTE;
                jse_pkg::CHR_BSLASH: esc = jse_pkg::CHR_BSLASH;
                jse_pkg::CHR_BS:     esc = jse_pkg::CHR_LO_B;
                jse_pkg::CHR_FF:     esc = jse_pkg::CHR_LO_F;
                jse_pkg::CHR_LF:     esc = jse_pkg::CHR_LO_N;
                jse_pkg::CHR_CR:     esc = jse_pkg::CHR_LO_R;
                jse_pkg::CHR_TAB:    esc = jse_pkg::CHR_LO_T;
                default:             esc = 8'h00;
            endcase
            if (esc != 8'h00) begin
                run[0] = jse_pkg::CHR_BSLASH;
                run[1] = esc;
                n = 2;
            end else begin
                run[0] = b;
                n = 1;
            end
        end
        if (keep) begin
            for (int i = 0; i < n; i++) begin
                oc.ch = run[i];
                oc.last = (i == n - 1);
                add_expected(oc);
            end
        end
    endfunction

    function automatic void add_row(input logic [7:0] b, input logic sos, input int len,
                                    input logic [47:0] text);
        t_dir_row r;
        r.octet = b;
        r.sos = sos;
        r.expect_len = len;
        r.expect_text = text;
        dir_rows.insert(dir_rows.size(), r);
    endfunction

    // A continuation byte, now and then an arbitrary one.
    function automatic logic [7:0] tail_byte();
        if ($urandom_range(0, 7) == 0) return 8'($urandom_range(0, 255));
        return {2'b10, 6'($urandom_range(0, 63))};
    endfunction

    // Offers one word, waits for it to be taken and records what it should produce.
    task automatic send_word(input logic [7:0] b, input logic sos, input int len,
                             input logic [47:0] text);
        int        gap;
        t_out_char oc;
        gap = pick_pause(0);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_byte_in <= b;
        i_start_of_string <= sos;
        do @(posedge i_clk); while (!o_in_ready);
        // Typed rows still step the predictor so its state stays in line.
        predict_escape(b, sos, len < 0);
        for (int i = 0; i < len; i++) begin
            oc.ch = text[8 * (len - 1 - i) +: 8];
            oc.last = (i == len - 1);
            add_expected(oc);
        end
        words_sent++;
        @(negedge i_clk);
    endtask

    // Output side: ready drops for random stalls.
    initial begin
        int stall;
        stall = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                stall--;
            end else begin
                i_out_ready <= 1'b1;
                stall = pick_pause(1);
            end
        end
    end

    // Compare each accepted output word with the oldest expectation.
    always @(posedge i_clk) begin
        t_out_char want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_chars.size() == 0) begin
                report_mismatch("unexpected char_out", o_char_out, 0);
            end else begin
                want = expected_chars.pop_front();
                if (o_char_out !== want.ch)
                    report_mismatch("char_out", o_char_out, want.ch);
                if (o_last_of_run !== want.last)
                    report_mismatch("last_of_run", o_last_of_run, want.last);
            end
        end
    end

    // Ends the run if nothing moves on either side for too long.
    initial begin
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) idle = 0;
            else idle++;
        end
        $display("Some tests failed");
        $finish;
    end

    // Main sequence: reset, directed table, random words, drain.
    initial begin
        int         roll;
        logic [7:0] lead;
        logic       sos;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_byte_in = 8'h00;
        i_start_of_string = 1'b0;
        err_count = 0;
        words_sent = 0;
        seq_left = 2'd0;
        seq_code = 16'd0;
        stretch_left[0] = 0;
        stretch_left[1] = 0;
        calm[0] = 1'b0;
        calm[1] = 1'b0;
        esc_set = '{jse_pkg::CHR_QUOTE, jse_pkg::CHR_BSLASH, jse_pkg::CHR_BS,
                    jse_pkg::CHR_FF, jse_pkg::CHR_LF, jse_pkg::CHR_CR, jse_pkg::CHR_TAB};

        // Plain bytes, among them both edges of the ASCII range, zero included.
        add_row(8'h41, 1'b0, 1, "A");
        add_row(8'h00, 1'b0, 1, 48'h00);
        add_row(8'h7F, 1'b0, 1, 48'h7F);
        add_row(8'h2F, 1'b0, 1, "/");
        // Every two-character escape.
        add_row(jse_pkg::CHR_QUOTE,  1'b0, 2, "\\\"");
        add_row(jse_pkg::CHR_BSLASH, 1'b0, 2, "\\\\");
        add_row(jse_pkg::CHR_BS,     1'b0, 2, "\\b");
        add_row(jse_pkg::CHR_FF,     1'b0, 2, "\\f");
        add_row(jse_pkg::CHR_LF,     1'b0, 2, "\\n");
        add_row(jse_pkg::CHR_CR,     1'b0, 2, "\\r");
        add_row(jse_pkg::CHR_TAB,    1'b0, 2, "\\t");
        // Two-byte sequences: lowest and highest code.
        add_row(8'h80, 1'b0, 0, 48'h0);
        add_row(8'h80, 1'b0, 6, "\\u0000");
        add_row(8'hDF, 1'b0, 0, 48'h0);
        add_row(8'hFF, 1'b0, 6, "\\u07FF");
        // Three-byte sequence at the top of the range.
        add_row(8'hFF, 1'b0, 0, 48'h0);
        add_row(8'hBF, 1'b0, 0, 48'h0);
        add_row(8'hBF, 1'b0, 6, "\\uFFFF");
        // A four-byte lead is taken as a three-byte lead.
        add_row(8'hF0, 1'b0, -1, 48'h0);
        add_row(8'h9F, 1'b0, -1, 48'h0);
        add_row(8'h98, 1'b0, -1, 48'h0);
        // An escape character inside a sequence is a plain continuation.
        add_row(8'hC2, 1'b0, 0, 48'h0);
        add_row(jse_pkg::CHR_QUOTE, 1'b0, 6, "\\u00A2");
        // Start of string drops the open sequence.
        add_row(8'hE2, 1'b0, 0, 48'h0);
        add_row(8'h78, 1'b1, 1, "x");

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[i])
            send_word(dir_rows[i].octet, dir_rows[i].sos, dir_rows[i].expect_len,
                      dir_rows[i].expect_text);

        // Mostly well-formed text with random content, some noise and cut sequences.
        while (words_sent < RANDOM_WORDS + dir_rows.size()) begin
            roll = $urandom_range(0, 99);
            sos = ($urandom_range(0, 9) == 0);
            if (roll < 35) begin
                send_word(8'($urandom_range(0, 127)), sos, -1, 48'h0);
            end else if (roll < 45) begin
                send_word(esc_set[3'($urandom_range(0, 6))], sos, -1, 48'h0);
            end else if (roll < 70) begin
                lead = 8'($urandom_range(8'h80, 8'hDF));
                send_word(lead, sos, -1, 48'h0);
                send_word(tail_byte(), 1'b0, -1, 48'h0);
            end else if (roll < 90) begin
                lead = 8'($urandom_range(8'hE0, 8'hFF));
                send_word(lead, sos, -1, 48'h0);
                send_word(tail_byte(), 1'b0, -1, 48'h0);
                send_word(tail_byte(), 1'b0, -1, 48'h0);
            end else if (roll < 95) begin
                lead = 8'($urandom_range(8'h80, 8'hFF));
                send_word(lead, sos, -1, 48'h0);
                send_word(8'($urandom_range(0, 255)), 1'b1, -1, 48'h0);
            end else begin
                send_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), -1, 48'h0);
            end
        end
        i_in_valid <= 1'b0;

        while (expected_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_chars.size() != 0)
            report_mismatch("words still expected", 0, expected_chars.size());

        if (err_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/jse_pkg.sv
src/jse_front.sv
src/jse_queue.sv
src/jse_back.sv
src/json_string_escaper_top.sv
tb/sv/testbench.sv
